// ===== hdl/temperature_to_mixing_params_top_assert.svh =====
// Assertion macros for the temperature to mixing parameters block.
// The clocked forms expect signals named clk and arst_n in the scope of use.
`ifndef TEMPERATURE_TO_MIXING_PARAMS_TOP_ASSERT_SVH
`define TEMPERATURE_TO_MIXING_PARAMS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TTMP_ASSERT_HOLDS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("ttmp: check failed");
`define TTMP_ASSERT_IMPLIES(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
	else $error("ttmp: check failed");
`else
`define TTMP_ASSERT_HOLDS(label, expr)
`define TTMP_ASSERT_IMPLIES(label, cond, expr)
`endif
`endif

// ===== hdl/ttmp_pkg.sv =====
package ttmp_pkg;

	localparam int DATA_W            = 32;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int CFG_IDX_W         = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE           = 4'd0,
		REG_INTERCEPT       = 4'd1,
		REG_EPS2_NUMERATOR  = 4'd2,
		REG_SIGMA_NUMERATOR = 4'd3,
		REG_EPS2_FLOOR      = 4'd4,
		REG_EPS2_CEILING    = 4'd5,
		REG_SIGMA_FLOOR     = 4'd6,
		REG_SIGMA_CEILING   = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] slope;
		logic signed [DATA_W-1:0] intercept;
		logic [DATA_W-1:0]        eps2_numerator;
		logic [DATA_W-1:0]        sigma_numerator;
		logic [DATA_W-1:0]        eps2_floor;
		logic [DATA_W-1:0]        eps2_ceiling;
		logic [DATA_W-1:0]        sigma_floor;
		logic [DATA_W-1:0]        sigma_ceiling;
	} cfg_t;

	// Raise to the floor first, then lower to the ceiling.
	function automatic logic [DATA_W-1:0] clamp_window(
		input logic [DATA_W-1:0] v,
		input logic [DATA_W-1:0] lo,
		input logic [DATA_W-1:0] hi
	);
		logic [DATA_W-1:0] r;
		r = (v < lo) ? lo : v;
		return (r > hi) ? hi : r;
	endfunction

endpackage

// ===== hdl/temperature_to_mixing_params_top.sv =====
// An accepted temperature passes the first divider, the chi register, the second divider
// and the output register on its way to its result word; FRAC_BITS defaults to sixteen.
// Throughput: one word per cycle; each divider retires one quotient bit per stage.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
module temperature_to_mixing_params_top #(
	parameter int FRAC_BITS = ttmp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ttmp_pkg::DATA_W-1:0]        temperature,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ttmp_pkg::DATA_W-1:0] chi,
	output logic [ttmp_pkg::DATA_W-1:0]        eps2,
	output logic [ttmp_pkg::DATA_W-1:0]        sigma,
	output logic                               chi_not_positive,
	input  logic                               cfg_we,
	input  logic [ttmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttmp_pkg::DATA_W-1:0]        cfg_data
);
	import ttmp_pkg::*;

	`include "temperature_to_mixing_params_top_assert.svh"

	// Dividend width of both divisions: a 32-bit magnitude shifted up by the
	// fraction bits. The quotient has the same width.
	localparam int DW = DATA_W + FRAC_BITS;
	localparam int SW = DW + 2;

	cfg_t cfg;

	// The pipeline moves as one: every stage advances unless the output
	// register holds a word that the receiver is stalling.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	ttmp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// First division: |slope| << FRAC_BITS over the temperature. The sign of
	// the slope and whether it is zero ride along; a zero slope forces the
	// term to zero, which also covers a zero temperature with a zero slope.
	// A zero temperature with a nonzero slope makes the divider return all
	// ones, which is far beyond the chi range and saturates correctly.
	logic                 slope_neg;
	logic [DATA_W-1:0]    slope_mag;
	logic [0:0][DW-1:0]   recip_dividend;
	logic                 recip_valid;
	logic [0:0][DW-1:0]   recip_quot;
	logic [1:0]           recip_pay;

	assign slope_neg         = cfg.slope[DATA_W-1];
	assign slope_mag         = slope_neg ? (DATA_W)'(-cfg.slope) : cfg.slope;
	assign recip_dividend[0] = {slope_mag, {FRAC_BITS{1'b0}}};

	ttmp_div #(
		.DW    (DW),
		.VW    (DATA_W),
		.LANES (1),
		.PW    (2)
	) u_div_recip (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (in_valid),
		.dividend    (recip_dividend),
		.divisor     (temperature),
		.in_payload  ({slope_neg, slope_mag == '0}),
		.out_valid   (recip_valid),
		.quotient    (recip_quot),
		.out_payload (recip_pay)
	);

	// Stage after the first division: apply the sign, add the intercept and
	// saturate chi to the signed 32-bit range.
	logic [DW-1:0]        term_mag;
	logic signed [SW-1:0] term;
	logic signed [SW-1:0] sum;
	logic [DATA_W-1:0]    chi_sat;
	logic                 sum_fits;
	logic                 valid_s2;
	logic [DATA_W-1:0]    chi_s2;

	assign term_mag = recip_pay[0] ? '0 : recip_quot[0];
	assign term     = recip_pay[1] ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
	assign sum      = term + {{(SW-DATA_W){cfg.intercept[DATA_W-1]}}, cfg.intercept};
	assign sum_fits = (sum[SW-1:DATA_W-1] == '0) || (&sum[SW-1:DATA_W-1]);
	assign chi_sat  = sum_fits ? sum[DATA_W-1:0]
	                           : (sum[SW-1] ? {1'b1, {(DATA_W-1){1'b0}}}
	                                        : {1'b0, {(DATA_W-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= recip_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chi_s2 <= chi_sat;
		end
	end

	// Second division: both numerators over chi in two lanes that share the
	// divisor. For chi not positive the quotients are ignored downstream.
	logic [1:0][DW-1:0] coef_dividend;
	logic               coef_valid;
	logic [1:0][DW-1:0] coef_quot;
	logic [DATA_W-1:0]  coef_chi;

	assign coef_dividend[0] = {cfg.eps2_numerator, {FRAC_BITS{1'b0}}};
	assign coef_dividend[1] = {cfg.sigma_numerator, {FRAC_BITS{1'b0}}};

	ttmp_div #(
		.DW    (DW),
		.VW    (DATA_W),
		.LANES (2),
		.PW    (DATA_W)
	) u_div_coef (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (valid_s2),
		.dividend    (coef_dividend),
		.divisor     (chi_s2),
		.in_payload  (chi_s2),
		.out_valid   (coef_valid),
		.quotient    (coef_quot),
		.out_payload (coef_chi)
	);

	// Output register: saturate the quotients, pick the forced values for a
	// zero or negative chi, and clamp to the windows.
	logic              chi_zero;
	logic              chi_neg;
	logic [DATA_W-1:0] eps2_raw;
	logic [DATA_W-1:0] sigma_raw;

	assign chi_zero = coef_chi == '0;
	assign chi_neg  = coef_chi[DATA_W-1];

	always_comb begin
		if (chi_zero) begin
			eps2_raw  = '1;
			sigma_raw = '1;
		end else if (chi_neg) begin
			eps2_raw  = '0;
			sigma_raw = '0;
		end else begin
			eps2_raw  = (coef_quot[0][DW-1:DATA_W] != '0) ? '1 : coef_quot[0][DATA_W-1:0];
			sigma_raw = (coef_quot[1][DW-1:DATA_W] != '0) ? '1 : coef_quot[1][DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chi              <= coef_chi;
			eps2             <= clamp_window(eps2_raw, cfg.eps2_floor, cfg.eps2_ceiling);
			sigma            <= clamp_window(sigma_raw, cfg.sigma_floor, cfg.sigma_ceiling);
			chi_not_positive <= chi_zero || chi_neg;
		end
	end

	// The flag must agree with the sign of the chi word it travels with.
	`TTMP_ASSERT_IMPLIES(a_flag_matches_chi, out_valid, chi_not_positive == (chi <= 0))
	// A clamped coefficient never exceeds its ceiling.
	`TTMP_ASSERT_IMPLIES(a_eps2_window, out_valid, eps2 <= cfg.eps2_ceiling)
	`TTMP_ASSERT_IMPLIES(a_sigma_window, out_valid, sigma <= cfg.sigma_ceiling)
	// Input is held off only while a finished word waits at the output.
	`TTMP_ASSERT_HOLDS(a_stall_source, !in_stall || out_valid)

endmodule

// ===== hdl/ttmp_cfg.sv =====
module ttmp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ttmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttmp_pkg::DATA_W-1:0]    cfg_data,
	output ttmp_pkg::cfg_t                 cfg
);
	import ttmp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope           <= '0;
			cfg_q.intercept       <= '0;
			cfg_q.eps2_numerator  <= DATA_W'(65536);
			cfg_q.sigma_numerator <= DATA_W'(65536);
			cfg_q.eps2_floor      <= '0;
			cfg_q.eps2_ceiling    <= '1;
			cfg_q.sigma_floor     <= '0;
			cfg_q.sigma_ceiling   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOPE:           cfg_q.slope           <= cfg_data;
				REG_INTERCEPT:       cfg_q.intercept       <= cfg_data;
				REG_EPS2_NUMERATOR:  cfg_q.eps2_numerator  <= cfg_data;
				REG_SIGMA_NUMERATOR: cfg_q.sigma_numerator <= cfg_data;
				REG_EPS2_FLOOR:      cfg_q.eps2_floor      <= cfg_data;
				REG_EPS2_CEILING:    cfg_q.eps2_ceiling    <= cfg_data;
				REG_SIGMA_FLOOR:     cfg_q.sigma_floor     <= cfg_data;
				REG_SIGMA_CEILING:   cfg_q.sigma_ceiling   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ttmp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage. All lanes share
// the divisor. The payload travels alongside the quotient.
module ttmp_div #(
	parameter int DW    = 48,
	parameter int VW    = 32,
	parameter int LANES = 1,
	parameter int PW    = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [LANES-1:0][DW-1:0]  dividend,
	input  logic [VW-1:0]             divisor,
	input  logic [PW-1:0]             in_payload,
	output logic                      out_valid,
	output logic [LANES-1:0][DW-1:0]  quotient,
	output logic [PW-1:0]             out_payload
);

	logic                     vld_s [DW];
	logic [LANES-1:0][VW-1:0] rem_s [DW];
	logic [LANES-1:0][DW-1:0] work_s [DW];
	logic [VW-1:0]            dv_s [DW];
	logic [PW-1:0]            pay_s [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic                     vld_in;
		logic [LANES-1:0][VW-1:0] rem_in;
		logic [LANES-1:0][DW-1:0] work_in;
		logic [VW-1:0]            dv_in;
		logic [PW-1:0]            pay_in;
		logic [LANES-1:0][VW-1:0] rem_nxt;
		logic [LANES-1:0][DW-1:0] work_nxt;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign work_in = dividend;
			assign dv_in   = divisor;
			assign pay_in  = in_payload;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
			assign dv_in   = dv_s[k-1];
			assign pay_in  = pay_s[k-1];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [VW:0] shifted;
			logic [VW:0] diff;
			assign shifted = {rem_in[l], work_in[l][DW-1]};
			assign diff    = shifted - {1'b0, dv_in};
			assign rem_nxt[l]  = diff[VW] ? shifted[VW-1:0] : diff[VW-1:0];
			assign work_nxt[l] = {work_in[l][DW-2:0], ~diff[VW]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nxt;
				work_s[k] <= work_nxt;
				dv_s[k]   <= dv_in;
				pay_s[k]  <= pay_in;
			end
		end
	end

	assign out_valid   = vld_s[DW-1];
	assign quotient    = work_s[DW-1];
	assign out_payload = pay_s[DW-1];

endmodule
